// ----- sv/smc_pkg.sv -----
`default_nettype none
package smc_pkg;

	localparam int WORD_W = 32;

	// one past the last defined instruction; words at or above it are ignored
	localparam logic [WORD_W-1:0] INSTR_COUNT = 32'd23;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ISSUE,
		ST_RDWAIT,
		ST_DECODE,
		ST_LOADWAIT,
		ST_PUSHWAIT,
		ST_PIPWAIT
	} state_t;

	typedef enum logic [1:0] {
		SH_HOLD,
		SH_PUSH,
		SH_POP1,
		SH_POP2
	} shift_t;

	typedef enum logic [1:0] {
		HOST_WRITE,
		HOST_READ,
		HOST_START,
		HOST_STEP
	} host_op_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_CHAR,
		KIND_NUM,
		KIND_READ
	} out_kind_t;

	typedef enum logic [1:0] {
		FLT_NONE,
		FLT_DATA,
		FLT_RET,
		FLT_ADDR
	} fault_t;

	typedef enum logic [4:0] {
		I_NOP, I_ADD, I_SUB, I_AND, I_OR, I_XOR, I_NOT, I_IN, I_OUT,
		I_LOAD, I_STOR, I_JMP, I_JZ, I_PUSH, I_DUP, I_SWAP, I_ROL3,
		I_OUTNUM, I_JNZ, I_DROP, I_PUSHIP, I_POPIP, I_DROPIP
	} instr_t;

	typedef struct packed {
		shift_t              sh;
		logic                load;
		logic [WORD_W-1:0]   val;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ----- sv/smc_in_if.sv -----
`default_nettype none
interface smc_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [11:0]        address;
	logic signed [31:0] write_data;
	logic signed [8:0]  in_char;

	modport source(output valid, output opcode, output address, output write_data,
		output in_char, input ready);
	modport sink(input valid, input opcode, input address, input write_data,
		input in_char, output ready);
endinterface
`default_nettype wire

// ----- sv/smc_out_if.sv -----
`default_nettype none
interface smc_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         out_kind;
	logic signed [31:0] out_value;
	logic               in_taken;
	logic               is_running;
	logic [1:0]         fault_code;

	modport source(output valid, output out_kind, output out_value, output in_taken,
		output is_running, output fault_code, input ready);
	modport sink(input valid, input out_kind, input out_value, input in_taken,
		input is_running, input fault_code, output ready);
endinterface
`default_nettype wire

// ----- sv/smc_cell.sv -----
`default_nettype none
module smc_cell import smc_pkg::*; (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [WORD_W-1:0] shallow,
	input  logic [WORD_W-1:0] deep1,
	input  logic [WORD_W-1:0] deep2,
	output logic [WORD_W-1:0] data
);

	logic [WORD_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= ctl.val;
		end else begin
			case (ctl.sh)
				SH_PUSH: data_q <= shallow;
				SH_POP1: data_q <= deep1;
				SH_POP2: data_q <= deep2;
				default: data_q <= data_q;
			endcase
		end
	end

	assign data = data_q;

endmodule
`default_nettype wire

// ----- sv/smc_ram.sv -----
`default_nettype none
module smc_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- sv/stack_machine_core.sv -----
`default_nettype none
// Channel | Dir | Payload                                             | Handshake
// cmd     | in  | opcode, address, write_data, in_char                 | valid/ready
// rsp     | out | out_kind, out_value, in_taken, is_running, fault_code | valid/ready
//
// A write, a start or a step of a stopped machine finishes in ST_ISSUE; a read and an
// executed step go on to ST_RDWAIT or ST_DECODE; LOAD, PUSH and PUSHIP that do not fault
// add a wait state, since the operand comes through the registered port of the word memory.
// Stacks are rows of cells that shift by one or two places in the state that completes the instruction.
// After reset a clearing pass writes zero to all MEM_WORDS words, one per cycle, before the
// first request is taken. cmd is ready again in the cycle after the response moves to the
// output register; while a stalled response holds that register, the next one waits and
// cmd stays low.
module stack_machine_core import smc_pkg::*; #(
	parameter int MEM_WORDS  = 4096,
	parameter int DATA_DEPTH = 64,
	parameter int RET_DEPTH  = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	smc_in_if.sink     cmd,
	smc_out_if.source  rsp
);

	localparam int AW = $clog2(MEM_WORDS);
	localparam int DW = $clog2(DATA_DEPTH + 1);
	localparam int RW = $clog2(RET_DEPTH + 1);
	localparam logic [WORD_W-1:0] MEM_LIM = WORD_W'(MEM_WORDS);
	localparam logic [AW:0]       MEM_LIM_W = (AW+1)'(MEM_WORDS);
	localparam logic [DW-1:0]     DD_MAX = DW'(DATA_DEPTH);
	localparam logic [RW-1:0]     RD_MAX = RW'(RET_DEPTH);

	state_t            state_q, state_d;
	logic [AW-1:0]     ip_q, ip_d;
	logic              run_q, run_d;
	fault_t            fault_q, fault_d;
	logic [DW-1:0]     dd_q, dd_d;
	logic [RW-1:0]     rd_q, rd_d;
	logic [AW-1:0]     clr_q, clr_d;
	logic              pend_q, pend_d;
	logic              out_v_q;

	host_op_t          req_op_q;
	logic [11:0]       req_addr_q;
	logic [WORD_W-1:0] req_wdata_q;
	logic signed [8:0] req_ch_q;

	out_kind_t         res_kind_q, res_kind_d;
	logic [WORD_W-1:0] res_val_q, res_val_d;
	logic              res_taken_q, res_taken_d;

	out_kind_t         out_kind_q;
	logic [WORD_W-1:0] out_val_q;
	logic              out_taken_q;
	logic              out_run_q;
	fault_t            out_fault_q;

	logic              ram_we;
	logic [AW-1:0]     ram_wa, ram_ra;
	logic [WORD_W-1:0] ram_wd, ram_rd;

	shift_t            d_sh, r_sh;
	logic [2:0]        d_ld;
	logic [WORD_W-1:0] d_lv [3];
	logic              r_ld;
	logic [WORD_W-1:0] r_lv;

	logic [WORD_W-1:0] d_q [DATA_DEPTH];
	logic [WORD_W-1:0] r_q [RET_DEPTH];
	logic [WORD_W-1:0] c0, c1, c2, r0;

	logic              accept, xfer, finish, take_jump;
	logic [WORD_W-1:0] host_a32, ip32;
	logic              host_bad;
	logic [AW-1:0]     host_idx, ip_a1, ip_a2;
	logic [AW:0]       ip_p4, ip_p8;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE) && !pend_q;
	assign xfer      = pend_q && (!out_v_q || rsp.ready);

	assign host_a32 = WORD_W'(req_addr_q);
	assign host_bad = host_a32 >= MEM_LIM;
	assign host_idx = host_a32[AW-1:0];
	assign ip32     = WORD_W'(ip_q);

	// next instruction address, and the one after (skip the inline literal)
	assign ip_p4 = {1'b0, ip_q} + (AW+1)'(4);
	assign ip_a1 = (ip_p4 >= MEM_LIM_W) ? '0 : ip_p4[AW-1:0];
	assign ip_p8 = {1'b0, ip_a1} + (AW+1)'(4);
	assign ip_a2 = (ip_p8 >= MEM_LIM_W) ? '0 : ip_p8[AW-1:0];

	assign c0 = d_q[0];
	assign c1 = d_q[1];
	assign c2 = d_q[2];
	assign r0 = r_q[0];

	assign take_jump = (ram_rd[4:0] == I_JZ) ? (c0 == '0) : (c0 != '0);

	smc_ram #(.W(WORD_W), .DEPTH(MEM_WORDS)) u_mem (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.raddr (ram_ra),
		.rdata (ram_rd)
	);

	for (genvar g = 0; g < DATA_DEPTH; g++) begin : g_dcell
		cell_ctl_t         ctl;
		logic [WORD_W-1:0] sh_w, dp1_w, dp2_w;
		if (g < 3) begin : g_ld
			assign ctl = '{sh: d_sh, load: d_ld[g], val: d_lv[g]};
		end else begin : g_nold
			assign ctl = '{sh: d_sh, load: 1'b0, val: '0};
		end
		if (g == 0) begin : g_top
			assign sh_w = '0;
		end else begin : g_mid
			assign sh_w = d_q[g-1];
		end
		if (g + 1 < DATA_DEPTH) begin : g_d1
			assign dp1_w = d_q[g+1];
		end else begin : g_nd1
			assign dp1_w = '0;
		end
		if (g + 2 < DATA_DEPTH) begin : g_d2
			assign dp2_w = d_q[g+2];
		end else begin : g_nd2
			assign dp2_w = '0;
		end
		smc_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.shallow (sh_w),
			.deep1   (dp1_w),
			.deep2   (dp2_w),
			.data    (d_q[g])
		);
	end

	for (genvar g = 0; g < RET_DEPTH; g++) begin : g_rcell
		cell_ctl_t         ctl;
		logic [WORD_W-1:0] sh_w, dp1_w;
		if (g == 0) begin : g_top
			assign ctl  = '{sh: r_sh, load: r_ld, val: r_lv};
			assign sh_w = '0;
		end else begin : g_mid
			assign ctl  = '{sh: r_sh, load: 1'b0, val: '0};
			assign sh_w = r_q[g-1];
		end
		if (g + 1 < RET_DEPTH) begin : g_d1
			assign dp1_w = r_q[g+1];
		end else begin : g_nd1
			assign dp1_w = '0;
		end
		smc_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.shallow (sh_w),
			.deep1   (dp1_w),
			.deep2   ('0),
			.data    (r_q[g])
		);
	end

	always_comb begin
		state_d     = state_q;
		ip_d        = ip_q;
		run_d       = run_q;
		fault_d     = fault_q;
		dd_d        = dd_q;
		rd_d        = rd_q;
		clr_d       = clr_q;
		pend_d      = pend_q && !xfer;
		res_kind_d  = res_kind_q;
		res_val_d   = res_val_q;
		res_taken_d = res_taken_q;
		ram_we      = 1'b0;
		ram_wa      = '0;
		ram_wd      = '0;
		ram_ra      = ip_q;
		d_sh        = SH_HOLD;
		d_ld        = '0;
		d_lv[0]     = '0;
		d_lv[1]     = '0;
		d_lv[2]     = '0;
		r_sh        = SH_HOLD;
		r_ld        = 1'b0;
		r_lv        = '0;
		finish      = 1'b0;

		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_wa = clr_q;
				clr_d  = clr_q + AW'(1);
				if (clr_q == AW'(MEM_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				res_kind_d  = KIND_NONE;
				res_val_d   = '0;
				res_taken_d = 1'b0;
				case (req_op_q)
					HOST_WRITE: begin
						finish = 1'b1;
						if (host_bad) begin
							run_d   = 1'b0;
							fault_d = FLT_ADDR;
						end else begin
							ram_we = 1'b1;
							ram_wa = host_idx;
							ram_wd = req_wdata_q;
						end
					end
					HOST_READ: begin
						res_kind_d = KIND_READ;
						if (host_bad) begin
							run_d   = 1'b0;
							fault_d = FLT_ADDR;
							finish  = 1'b1;
						end else begin
							ram_ra  = host_idx;
							state_d = ST_RDWAIT;
						end
					end
					HOST_START: begin
						finish = 1'b1;
						if (host_bad) begin
							run_d   = 1'b0;
							fault_d = FLT_ADDR;
						end else begin
							ip_d    = host_idx;
							run_d   = 1'b1;
							fault_d = FLT_NONE;
						end
					end
					default: begin
						if (run_q) begin
							ram_ra  = ip_q;
							state_d = ST_DECODE;
						end else begin
							finish = 1'b1;
						end
					end
				endcase
			end
			ST_RDWAIT: begin
				res_val_d = ram_rd;
				finish    = 1'b1;
			end
			ST_DECODE: begin
				finish = 1'b1;
				if (ram_rd < INSTR_COUNT) begin
					case (instr_t'(ram_rd[4:0]))
						I_NOP: ip_d = ip_a1;
						I_ADD, I_SUB, I_AND, I_OR, I_XOR: begin
							if (dd_q < DW'(2)) begin
								run_d = 1'b0; fault_d = FLT_DATA;
							end else begin
								d_sh  = SH_POP1;
								d_ld[0] = 1'b1;
								case (instr_t'(ram_rd[4:0]))
									I_ADD:   d_lv[0] = c0 + c1;
									I_SUB:   d_lv[0] = c0 - c1;
									I_AND:   d_lv[0] = c0 & c1;
									I_OR:    d_lv[0] = c0 | c1;
									default: d_lv[0] = c0 ^ c1;
								endcase
								dd_d = dd_q - DW'(1);
								ip_d = ip_a1;
							end
						end
						I_NOT: begin
							if (dd_q < DW'(1)) begin
								run_d = 1'b0; fault_d = FLT_DATA;
							end else begin
								d_ld[0] = 1'b1;
								d_lv[0] = WORD_W'(c0 == '0);
								ip_d    = ip_a1;
							end
						end
						I_IN: begin
							if (dd_q >= DD_MAX) begin
								run_d = 1'b0; fault_d = FLT_DATA;
							end else begin
								d_sh        = SH_PUSH;
								d_ld[0]     = 1'b1;
								d_lv[0]     = WORD_W'(req_ch_q);
								dd_d        = dd_q + DW'(1);
								res_taken_d = 1'b1;
								ip_d        = ip_a1;
							end
						end
						I_OUT, I_OUTNUM: begin
							if (dd_q < DW'(1)) begin
								run_d = 1'b0; fault_d = FLT_DATA;
							end else begin
								d_sh = SH_POP1;
								dd_d = dd_q - DW'(1);
								if (ram_rd[4:0] == I_OUT) begin
									res_kind_d = KIND_CHAR;
									res_val_d  = {24'b0, c0[7:0]};
								end else begin
									res_kind_d = KIND_NUM;
									res_val_d  = c0;
								end
								ip_d = ip_a1;
							end
						end
						I_LOAD: begin
							if (dd_q < DW'(1)) begin
								run_d = 1'b0; fault_d = FLT_DATA;
							end else if (c0 >= MEM_LIM) begin
								run_d = 1'b0; fault_d = FLT_ADDR;
							end else begin
								ram_ra  = c0[AW-1:0];
								state_d = ST_LOADWAIT;
								finish  = 1'b0;
							end
						end
						I_STOR: begin
							if (dd_q < DW'(1)) begin
								run_d = 1'b0; fault_d = FLT_DATA;
							end else if (c0 >= MEM_LIM) begin
								run_d = 1'b0; fault_d = FLT_ADDR;
							end else if (dd_q < DW'(2)) begin
								run_d = 1'b0; fault_d = FLT_DATA;
							end else begin
								ram_we = 1'b1;
								ram_wa = c0[AW-1:0];
								ram_wd = c1;
								d_sh   = SH_POP2;
								dd_d   = dd_q - DW'(2);
								ip_d   = ip_a1;
							end
						end
						I_JMP: begin
							if (dd_q < DW'(1)) begin
								run_d = 1'b0; fault_d = FLT_DATA;
							end else if (c0 >= MEM_LIM) begin
								run_d = 1'b0; fault_d = FLT_ADDR;
							end else begin
								d_sh = SH_POP1;
								dd_d = dd_q - DW'(1);
								// jump to self halts
								if (c0 == ip32) begin
									run_d = 1'b0;
								end else begin
									ip_d = c0[AW-1:0];
								end
							end
						end
						I_JZ, I_JNZ: begin
							if (dd_q < DW'(2)) begin
								run_d = 1'b0; fault_d = FLT_DATA;
							end else if (take_jump && (c1 >= MEM_LIM)) begin
								run_d = 1'b0; fault_d = FLT_ADDR;
							end else begin
								d_sh = SH_POP2;
								dd_d = dd_q - DW'(2);
								ip_d = take_jump ? c1[AW-1:0] : ip_a1;
							end
						end
						I_PUSH: begin
							if (dd_q >= DD_MAX) begin
								run_d = 1'b0; fault_d = FLT_DATA;
							end else begin
								ram_ra  = ip_a1;
								state_d = ST_PUSHWAIT;
								finish  = 1'b0;
							end
						end
						I_DUP: begin
							if (dd_q < DW'(1) || dd_q >= DD_MAX) begin
								run_d = 1'b0; fault_d = FLT_DATA;
							end else begin
								d_sh    = SH_PUSH;
								d_ld[0] = 1'b1;
								d_lv[0] = c0;
								dd_d    = dd_q + DW'(1);
								ip_d    = ip_a1;
							end
						end
						I_SWAP: begin
							if (dd_q < DW'(2)) begin
								run_d = 1'b0; fault_d = FLT_DATA;
							end else begin
								d_ld[0] = 1'b1;
								d_lv[0] = c1;
								d_ld[1] = 1'b1;
								d_lv[1] = c0;
								ip_d    = ip_a1;
							end
						end
						I_ROL3: begin
							if (dd_q < DW'(3)) begin
								run_d = 1'b0; fault_d = FLT_DATA;
							end else begin
								d_ld    = 3'b111;
								d_lv[0] = c2;
								d_lv[1] = c0;
								d_lv[2] = c1;
								ip_d    = ip_a1;
							end
						end
						I_DROP: begin
							if (dd_q < DW'(1)) begin
								run_d = 1'b0; fault_d = FLT_DATA;
							end else begin
								d_sh = SH_POP1;
								dd_d = dd_q - DW'(1);
								ip_d = ip_a1;
							end
						end
						I_PUSHIP: begin
							if (rd_q >= RD_MAX) begin
								run_d = 1'b0; fault_d = FLT_RET;
							end else begin
								ram_ra  = ip_a1;
								state_d = ST_PIPWAIT;
								finish  = 1'b0;
							end
						end
						I_POPIP: begin
							if (rd_q < RW'(1)) begin
								run_d = 1'b0; fault_d = FLT_RET;
							end else if (r0 >= MEM_LIM) begin
								run_d = 1'b0; fault_d = FLT_ADDR;
							end else begin
								r_sh = SH_POP1;
								rd_d = rd_q - RW'(1);
								ip_d = r0[AW-1:0];
							end
						end
						I_DROPIP: begin
							if (rd_q < RW'(1)) begin
								run_d = 1'b0; fault_d = FLT_RET;
							end else begin
								r_sh = SH_POP1;
								rd_d = rd_q - RW'(1);
								ip_d = ip_a1;
							end
						end
						default: ;
					endcase
				end
			end
			ST_LOADWAIT: begin
				d_ld[0] = 1'b1;
				d_lv[0] = ram_rd;
				ip_d    = ip_a1;
				finish  = 1'b1;
			end
			ST_PUSHWAIT: begin
				d_sh    = SH_PUSH;
				d_ld[0] = 1'b1;
				d_lv[0] = ram_rd;
				dd_d    = dd_q + DW'(1);
				ip_d    = ip_a2;
				finish  = 1'b1;
			end
			ST_PIPWAIT: begin
				r_sh   = SH_PUSH;
				r_ld   = 1'b1;
				r_lv   = ram_rd;
				rd_d   = rd_q + RW'(1);
				ip_d   = ip_a2;
				finish = 1'b1;
			end
			default: state_d = ST_IDLE;
		endcase

		if (finish) begin
			pend_d  = 1'b1;
			state_d = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ip_q    <= '0;
			run_q   <= 1'b1;
			fault_q <= FLT_NONE;
			dd_q    <= '0;
			rd_q    <= '0;
			clr_q   <= '0;
			pend_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ip_q    <= ip_d;
			run_q   <= run_d;
			fault_q <= fault_d;
			dd_q    <= dd_d;
			rd_q    <= rd_d;
			clr_q   <= clr_d;
			pend_q  <= pend_d;
			if (xfer) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_op_q    <= host_op_t'(cmd.opcode);
			req_addr_q  <= cmd.address;
			req_wdata_q <= cmd.write_data;
			req_ch_q    <= cmd.in_char;
		end
		res_kind_q  <= res_kind_d;
		res_val_q   <= res_val_d;
		res_taken_q <= res_taken_d;
		// status reflects the machine after the request that just finished
		if (xfer) begin
			out_kind_q  <= res_kind_q;
			out_val_q   <= res_val_q;
			out_taken_q <= res_taken_q;
			out_run_q   <= run_q;
			out_fault_q <= fault_q;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.out_kind   = out_kind_q;
	assign rsp.out_value  = $signed(out_val_q);
	assign rsp.in_taken   = out_taken_q;
	assign rsp.is_running = out_run_q;
	assign rsp.fault_code = out_fault_q;

`ifndef SYNTHESIS
	a_dd_bound: assert property (@(posedge clk) disable iff (!arst_n) dd_q <= DD_MAX)
		else $error("data stack depth beyond limit");
	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n) rd_q <= RD_MAX)
		else $error("return stack depth beyond limit");
	a_fault_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(fault_q != FLT_NONE) |-> !run_q)
		else $error("fault recorded while running");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !pend_q)
		else $error("request taken while a response is pending");
	a_issue_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_ISSUE))
		else $error("accepted request not issued");
`endif

endmodule
`default_nettype wire
